@@ rtl/core/taa_pkg.sv @@
`timescale 1ns / 1ps

package taa_pkg;

  localparam int VEC_W         = 41;
  localparam int CORDIC_ROUNDS = 24;
  localparam int Z_W           = 29;
  localparam int LANE_LAT      = 3 + CORDIC_ROUNDS + 1;

  localparam logic [15:0] DEG180_Q88 = 16'd46080;
  localparam logic signed [Z_W-1:0] DEG180_Z = 29'sd188743680;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_ROUNDS] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

  typedef struct packed {
    logic [VEC_W-1:0] x;
    logic [VEC_W-1:0] y;
    logic             obtuse;
  } taa_vec_t;

endpackage

@@ rtl/core/taa_cordic_lane.sv @@
`timescale 1ns / 1ps

module taa_cordic_lane (
  input  logic             clk,
  input  logic             en,
  input  taa_pkg::taa_vec_t vec_i,
  output logic [15:0]      angle_o
);
  import taa_pkg::*;

  localparam int CW = VEC_W + 4;

  function automatic taa_vec_t norm_step(input taa_vec_t v, input int unsigned k);
    logic [VEC_W-1:0] t;
    taa_vec_t         r;
    t = v.x | v.y;
    r = v;
    if ((t >> (VEC_W - k)) == '0) begin
      r.x = v.x << k;
      r.y = v.y << k;
    end
    return r;
  endfunction

  // normalize so the larger of x, y has its top bit set
  taa_vec_t n0_r, n1_r, n2_r, n0_nxt, n1_nxt, n2_nxt;
  logic     z0_r, z1_r, z2_r, z0_nxt;

  always_comb begin
    n0_nxt = norm_step(norm_step(vec_i, 32), 16);
    z0_nxt = ~|(vec_i.x | vec_i.y);
    n1_nxt = norm_step(norm_step(n0_r, 8), 4);
    n2_nxt = norm_step(norm_step(n1_r, 2), 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= n0_nxt;
      z0_r <= z0_nxt;
      n1_r <= n1_nxt;
      z1_r <= z0_r;
      n2_r <= n2_nxt;
      z2_r <= z1_r;
    end
  end

  // vectoring rounds
  logic signed [CW-1:0]  cx_w [0:CORDIC_ROUNDS];
  logic signed [CW-1:0]  cy_w [0:CORDIC_ROUNDS];
  logic signed [Z_W-1:0] zz_w [0:CORDIC_ROUNDS];
  logic                  ob_w [0:CORDIC_ROUNDS];
  logic                  zf_w [0:CORDIC_ROUNDS];

  assign cx_w[0] = $signed({4'b0, n2_r.x});
  assign cy_w[0] = $signed({4'b0, n2_r.y});
  assign zz_w[0] = '0;
  assign ob_w[0] = n2_r.obtuse;
  assign zf_w[0] = z2_r;

  for (genvar i = 0; i < CORDIC_ROUNDS; i++) begin : g_round
    logic signed [CW-1:0]  cx_r, cy_r, cx_nxt, cy_nxt;
    logic signed [Z_W-1:0] zz_r, zz_nxt;
    logic                  ob_r, zf_r;

    always_comb begin
      if (!cy_w[i][CW-1]) begin
        cx_nxt = cx_w[i] + (cy_w[i] >>> i);
        cy_nxt = cy_w[i] - (cx_w[i] >>> i);
        zz_nxt = zz_w[i] + ATAN_TAB[i];
      end else begin
        cx_nxt = cx_w[i] - (cy_w[i] >>> i);
        cy_nxt = cy_w[i] + (cx_w[i] >>> i);
        zz_nxt = zz_w[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        zz_r <= zz_nxt;
        ob_r <= ob_w[i];
        zf_r <= zf_w[i];
      end
    end

    assign cx_w[i+1] = cx_r;
    assign cy_w[i+1] = cy_r;
    assign zz_w[i+1] = zz_r;
    assign ob_w[i+1] = ob_r;
    assign zf_w[i+1] = zf_r;
  end

  // clamp, fold for obtuse, round to q8.8
  logic signed [Z_W-1:0] za, zb, zr;
  logic [16:0]           q;
  logic [15:0]           angle_r, angle_nxt;

  always_comb begin
    za = zz_w[CORDIC_ROUNDS][Z_W-1] ? '0 : zz_w[CORDIC_ROUNDS];
    zb = ob_w[CORDIC_ROUNDS] ? (DEG180_Z - za) : za;
    if (zb[Z_W-1]) begin
      zb = '0;
    end
    zr = zb + 29'sd2048;
    q  = zr[28:12];
    if (zf_w[CORDIC_ROUNDS]) begin
      angle_nxt = '0;
    end else if (q > {1'b0, DEG180_Q88}) begin
      angle_nxt = DEG180_Q88;
    end else begin
      angle_nxt = q[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign angle_o = angle_r;

endmodule

@@ rtl/core/triangle_area_and_angles_core.sv @@
`timescale 1ns / 1ps
// channel   | valid     | ready     | payload
// input     | in_valid  | in_ready  | in_side_a, in_side_b, in_side_c
// result    | out_valid | out_ready | out_is_triangle, out_area_value, out_angle_opposite_a/b/c
//
// one triangle per cycle while the result is not stalled
// pipeline of 4 product stages, 31 square root stages, 28 angle stages, 1 output stage
// rst_n synchronous, clears the per-stage valid bits only
// a stalled result holds the whole pipeline; in_ready = !out_valid || out_ready

module triangle_area_and_angles_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_side_a,
  input  logic [15:0] in_side_b,
  input  logic [15:0] in_side_c,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_triangle,
  output logic [31:0] out_area_value,
  output logic [15:0] out_angle_opposite_a,
  output logic [15:0] out_angle_opposite_b,
  output logic [15:0] out_angle_opposite_c
);
  import taa_pkg::*;

  localparam int SQ_STAGES = 31;
  localparam int DEPTH     = 4 + SQ_STAGES + LANE_LAT + 1;

  typedef struct packed {
    logic        big;
    logic [33:0] maga;
    logic        oba;
    logic [33:0] magb;
    logic        obb;
    logic        tri_ok;
  } sq_side_t;

  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic             en;

  assign en        = !vld_r[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[DEPTH-1];
  assign vld_nxt   = {vld_r[DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: sums, differences, squares
  logic [17:0] sum_r, sum_nxt;
  logic [16:0] d1_r, d2_r, d3_r, d1_nxt, d2_nxt, d3_nxt;
  logic [31:0] asq_r, bsq_r, csq_r, asq_nxt, bsq_nxt, csq_nxt;
  logic        tri1_r, tri1_nxt;

  always_comb begin
    sum_nxt  = {2'b0, in_side_a} + {2'b0, in_side_b} + {2'b0, in_side_c};
    d1_nxt   = {1'b0, in_side_b} + {1'b0, in_side_c} - {1'b0, in_side_a};
    d2_nxt   = {1'b0, in_side_a} + {1'b0, in_side_c} - {1'b0, in_side_b};
    d3_nxt   = {1'b0, in_side_a} + {1'b0, in_side_b} - {1'b0, in_side_c};
    asq_nxt  = in_side_a * in_side_a;
    bsq_nxt  = in_side_b * in_side_b;
    csq_nxt  = in_side_c * in_side_c;
    tri1_nxt = ({1'b0, in_side_a} + {1'b0, in_side_b} > {1'b0, in_side_c}) &&
               ({1'b0, in_side_a} + {1'b0, in_side_c} > {1'b0, in_side_b}) &&
               ({1'b0, in_side_b} + {1'b0, in_side_c} > {1'b0, in_side_a});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
      asq_r  <= asq_nxt;
      bsq_r  <= bsq_nxt;
      csq_r  <= csq_nxt;
      tri1_r <= tri1_nxt;
    end
  end

  // stage 2: pair products and cosine terms
  logic [34:0] p1_r, p1_nxt;
  logic [33:0] p2_r, p2_nxt;
  logic [34:0] cta_r, ctb_r, cta_nxt, ctb_nxt;
  logic        tri2_r;

  always_comb begin
    p1_nxt  = sum_r * d1_r;
    p2_nxt  = d2_r * d3_r;
    cta_nxt = {3'b0, bsq_r} + {3'b0, csq_r} - {3'b0, asq_r};
    ctb_nxt = {3'b0, asq_r} + {3'b0, csq_r} - {3'b0, bsq_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      cta_r  <= cta_nxt;
      ctb_r  <= ctb_nxt;
      tri2_r <= tri1_r;
    end
  end

  // stage 3: partial products, cosine magnitudes
  logic [51:0] pplo_r, pphi_r, pplo_nxt, pphi_nxt;
  logic [33:0] maga_r, magb_r, maga_nxt, magb_nxt;
  logic [34:0] nega, negb;
  logic        oba_r, obb_r, tri3_r;

  always_comb begin
    pplo_nxt = p1_r * p2_r[16:0];
    pphi_nxt = p1_r * p2_r[33:17];
    nega     = -cta_r;
    negb     = -ctb_r;
    maga_nxt = cta_r[34] ? nega[33:0] : cta_r[33:0];
    magb_nxt = ctb_r[34] ? negb[33:0] : ctb_r[33:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pplo_r <= pplo_nxt;
      pphi_r <= pphi_nxt;
      maga_r <= maga_nxt;
      magb_r <= magb_nxt;
      oba_r  <= cta_r[34];
      obb_r  <= ctb_r[34];
      tri3_r <= tri2_r;
    end
  end

  // stage 4: full product, pick root operand
  logic [69:0] prod;
  logic        big;
  logic [61:0] v_r, v_nxt;
  sq_side_t    side4_r, side4_nxt;

  always_comb begin
    prod      = {18'b0, pplo_r} + {1'b0, pphi_r, 17'b0};
    big       = |prod[69:62];
    v_nxt     = big ? {16'b0, prod[65:20]} : prod[61:0];
    side4_nxt = '{big: big, maga: maga_r, oba: oba_r, magb: magb_r, obb: obb_r,
                  tri_ok: tri3_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r     <= v_nxt;
      side4_r <= side4_nxt;
    end
  end

  // square root, one result bit per stage
  logic [63:0] rem_w  [0:SQ_STAGES];
  logic [30:0] root_w [0:SQ_STAGES];
  sq_side_t    side_w [0:SQ_STAGES];

  assign rem_w[0]  = {2'b0, v_r};
  assign root_w[0] = '0;
  assign side_w[0] = side4_r;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int POS = SQ_STAGES - 1 - k;
    logic [63:0] term;
    logic [63:0] rem_r, rem_nxt;
    logic [30:0] root_r, root_nxt;
    sq_side_t    side_r;

    always_comb begin
      term = ({33'd0, root_w[k]} << (POS + 1)) | (64'd1 << (2 * POS));
      if (rem_w[k] >= term) begin
        rem_nxt  = rem_w[k] - term;
        root_nxt = root_w[k] | (31'd1 << POS);
      end else begin
        rem_nxt  = rem_w[k];
        root_nxt = root_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        side_r <= side_w[k];
      end
    end

    assign rem_w[k+1]  = rem_r;
    assign root_w[k+1] = root_r;
    assign side_w[k+1] = side_r;
  end

  // angle lanes
  logic [30:0] root_f;
  sq_side_t    side_f;
  taa_vec_t    vec_a, vec_b;
  logic [31:0] area_w;
  logic [15:0] ang_a, ang_b;

  assign root_f = root_w[SQ_STAGES];
  assign side_f = side_w[SQ_STAGES];

  always_comb begin
    vec_a.x      = side_f.big ? {17'b0, side_f.maga[33:10]} : {7'b0, side_f.maga};
    vec_a.y      = {10'b0, root_f};
    vec_a.obtuse = side_f.oba;
    vec_b.x      = side_f.big ? {17'b0, side_f.magb[33:10]} : {7'b0, side_f.magb};
    vec_b.y      = {10'b0, root_f};
    vec_b.obtuse = side_f.obb;
    area_w       = side_f.big ? {1'b0, root_f} : {11'b0, root_f[30:10]};
  end

  taa_cordic_lane u_lane_a (
    .clk     (clk),
    .en      (en),
    .vec_i   (vec_a),
    .angle_o (ang_a)
  );

  taa_cordic_lane u_lane_b (
    .clk     (clk),
    .en      (en),
    .vec_i   (vec_b),
    .angle_o (ang_b)
  );

  logic [31:0] dl_area_w [0:LANE_LAT];
  logic        dl_tri_w  [0:LANE_LAT];

  assign dl_area_w[0] = area_w;
  assign dl_tri_w[0]  = side_f.tri_ok;

  for (genvar j = 0; j < LANE_LAT; j++) begin : g_dly
    logic [31:0] area_r;
    logic        tri_r;

    always_ff @(posedge clk) begin
      if (en) begin
        area_r <= dl_area_w[j];
        tri_r  <= dl_tri_w[j];
      end
    end

    assign dl_area_w[j+1] = area_r;
    assign dl_tri_w[j+1]  = tri_r;
  end

  // output stage
  logic        tri_f;
  logic [16:0] ang_sum;
  logic        tri_o_r, tri_o_nxt;
  logic [31:0] area_o_r, area_o_nxt;
  logic [15:0] anga_o_r, angb_o_r, angc_o_r, anga_o_nxt, angb_o_nxt, angc_o_nxt;

  always_comb begin
    tri_f      = dl_tri_w[LANE_LAT];
    ang_sum    = {1'b0, ang_a} + {1'b0, ang_b};
    tri_o_nxt  = tri_f;
    area_o_nxt = tri_f ? dl_area_w[LANE_LAT] : '0;
    anga_o_nxt = tri_f ? ang_a : '0;
    angb_o_nxt = tri_f ? ang_b : '0;
    if (!tri_f || ang_sum >= {1'b0, DEG180_Q88}) begin
      angc_o_nxt = '0;
    end else begin
      angc_o_nxt = DEG180_Q88 - ang_a - ang_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tri_o_r  <= tri_o_nxt;
      area_o_r <= area_o_nxt;
      anga_o_r <= anga_o_nxt;
      angb_o_r <= angb_o_nxt;
      angc_o_r <= angc_o_nxt;
    end
  end

  assign out_is_triangle      = tri_o_r;
  assign out_area_value       = area_o_r;
  assign out_angle_opposite_a = anga_o_r;
  assign out_angle_opposite_b = angb_o_r;
  assign out_angle_opposite_c = angc_o_r;

endmodule

@@ rtl/core/taa_checker.sv @@
`timescale 1ns / 1ps

module taa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_triangle,
  input logic [31:0] out_area_value,
  input logic [15:0] out_angle_opposite_a,
  input logic [15:0] out_angle_opposite_b,
  input logic [15:0] out_angle_opposite_c
);
  import taa_pkg::*;

  logic [16:0] ang_sum;
  assign ang_sum = {1'b0, out_angle_opposite_a} + {1'b0, out_angle_opposite_b};

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_area_value) &&
    $stable(out_angle_opposite_a) && $stable(out_is_triangle))
    else $error("stalled result changed");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_triangle |-> out_area_value == '0 &&
    out_angle_opposite_a == '0 && out_angle_opposite_b == '0 &&
    out_angle_opposite_c == '0)
    else $error("non-triangle result not zero");

  a_angle_c: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_triangle |->
    (ang_sum >= {1'b0, DEG180_Q88} && out_angle_opposite_c == '0) ||
    (ang_sum < {1'b0, DEG180_Q88} &&
     {1'b0, out_angle_opposite_c} == {1'b0, DEG180_Q88} - ang_sum))
    else $error("third angle inconsistent");

  a_angle_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angle_opposite_a <= DEG180_Q88 &&
    out_angle_opposite_b <= DEG180_Q88)
    else $error("angle above 180 degrees");

endmodule

bind triangle_area_and_angles_core taa_checker u_taa_checker (.*);
